// ===== rtl/lba_pkg.sv =====
// ----------------------------------------------------------------------------
// lba_pkg
// Shared types and constants of the LIFO block allocator.
// ----------------------------------------------------------------------------
package lba_pkg;

  localparam int unsigned MaxEntriesDefault = 64;
  localparam logic [15:0] MemSizeReset      = 16'd1000;

  // Command codes
  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_FREE  = 2'd1;
  localparam logic [1:0] CMD_DUMP  = 2'd2;
  localparam logic [1:0] CMD_QUERY = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;
  localparam logic [1:0] ST_ZERO    = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FREE,
    S_DUMP
  } lba_state_e;

endpackage

// ===== rtl/lifo_block_allocator.sv =====
// ----------------------------------------------------------------------------
// lifo_block_allocator
// Stack-style bump allocator; block table held in synchronous memories.
// ----------------------------------------------------------------------------
// A command word is taken when start_i is high and busy_o is low. For
// allocate and query the result strobes on done_o in the next cycle and
// busy_o stays low, so commands may follow back to back. Free passes through
// S_FREE because the newest block's range is read from the block table,
// whose read port is registered. A dump issues one read per live block
// through the same port, and the result words come out on consecutive
// cycles, the final one with last_o set. A free or a dump on an empty stack
// answers in the next cycle. Each result word is valid for exactly one cycle
// while done_o is high; the receiver cannot stall, so sample it then. No
// clearing pass runs after reset: only table entries below the block count
// ever reach a result. cfg_ready_o is always high; write memory_size only
// while no command is in flight.
// ----------------------------------------------------------------------------
module lifo_block_allocator
  import lba_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = MaxEntriesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // command channel
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  cmd_i,
  input  logic [15:0] size_i,
  // configuration channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i,
  // result channel
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [15:0] block_start_o,
  output logic [15:0] block_end_o,
  output logic [15:0] free_amount_o,
  output logic        last_o
);

  // Table address width and block count width (count must hold MAX_ENTRIES).
  localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
  localparam logic [CW-1:0] CountFull = CW'(MAX_ENTRIES);

  // Saturating free space: memory size minus units in use, floor at zero.
  function automatic logic [15:0] remaining(input logic [15:0] ms,
                                            input logic [15:0] used);
    remaining = (ms > used) ? (ms - used) : 16'd0;
  endfunction

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  lba_state_e state_q, state_d;

  logic [15:0]   mem_size_q;
  logic [CW-1:0] count_q, count_d;
  logic [15:0]   used_q, used_d;
  logic [AW-1:0] dump_idx_q, dump_idx_d;

  // Block table: start and end unit of each live block, oldest at index 0.
  logic [15:0] start_mem [MAX_ENTRIES];
  logic [15:0] end_mem   [MAX_ENTRIES];
  logic [15:0] rd_start_q, rd_end_q;
  logic [AW-1:0] rd_addr;
  logic          mem_we;
  logic [AW-1:0] wr_addr;
  logic [15:0]   wr_start, wr_end;

  // Result register, one word per strobe.
  logic        done_q;
  logic [1:0]  status_q, status_d;
  logic [15:0] bs_q, bs_d;
  logic [15:0] be_q, be_d;
  logic [15:0] free_q, free_d;
  logic        last_q, last_d;
  logic        res_load;

  logic          accept;
  logic          stack_empty;
  logic          stack_full;
  logic [15:0]   rem_now;
  logic [15:0]   alloc_used;
  logic [15:0]   freed_len;
  logic [15:0]   free_used;
  logic          dump_last;
  logic [CW-1:0] count_dec;

  assign accept      = start_i && (state_q == S_IDLE);
  assign stack_empty = (count_q == '0);
  assign stack_full  = (count_q >= CountFull);
  assign rem_now     = remaining(mem_size_q, used_q);
  assign alloc_used  = used_q + size_i;
  assign freed_len   = rd_end_q - rd_start_q + 16'd1;
  assign free_used   = used_q - freed_len;
  assign count_dec   = count_q - CW'(1);
  // The word being read back is the newest block when index + 1 meets count.
  assign dump_last   = ((CW'(dump_idx_q) + CW'(1)) == count_q);

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept && (cmd_i == CMD_FREE) && !stack_empty) begin
          state_d = S_FREE;
        end else if (accept && (cmd_i == CMD_DUMP) && !stack_empty) begin
          state_d = S_DUMP;
        end
      end
      S_FREE: begin
        state_d = S_IDLE;
      end
      S_DUMP: begin
        if (dump_last) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Datapath control and result formation
  // --------------------------------------------------------------------------
  always_comb begin
    count_d    = count_q;
    used_d     = used_q;
    dump_idx_d = dump_idx_q;
    rd_addr    = dump_idx_q;
    mem_we     = 1'b0;
    wr_addr    = count_q[AW-1:0];
    wr_start   = used_q;
    wr_end     = alloc_used - 16'd1;
    res_load   = 1'b0;
    status_d   = ST_OK;
    bs_d       = 16'd0;
    be_d       = 16'd0;
    free_d     = rem_now;
    last_d     = 1'b1;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (cmd_i)
            CMD_ALLOC: begin
              res_load = 1'b1;
              if (size_i == 16'd0) begin
                status_d = ST_ZERO;
              end else if (stack_full || (size_i > rem_now)) begin
                status_d = ST_NOSPACE;
              end else begin
                // Push: new block starts right after the newest one.
                mem_we  = 1'b1;
                count_d = count_q + CW'(1);
                used_d  = alloc_used;
                bs_d    = used_q;
                be_d    = alloc_used - 16'd1;
                free_d  = remaining(mem_size_q, alloc_used);
              end
            end
            CMD_FREE: begin
              if (stack_empty) begin
                res_load = 1'b1;
                status_d = ST_EMPTY;
              end else begin
                // Pop now, fetch the newest range for the next cycle.
                rd_addr = count_dec[AW-1:0];
                count_d = count_dec;
              end
            end
            CMD_DUMP: begin
              if (stack_empty) begin
                res_load = 1'b1;
                status_d = ST_EMPTY;
              end else begin
                rd_addr    = '0;
                dump_idx_d = '0;
              end
            end
            CMD_QUERY: begin
              res_load = 1'b1;
            end
            default: begin
              res_load = 1'b1;
            end
          endcase
        end
      end
      S_FREE: begin
        res_load = 1'b1;
        used_d   = free_used;
        bs_d     = rd_start_q;
        be_d     = rd_end_q;
        free_d   = remaining(mem_size_q, free_used);
      end
      S_DUMP: begin
        res_load = 1'b1;
        bs_d     = rd_start_q;
        be_d     = rd_end_q;
        last_d   = dump_last;
        if (!dump_last) begin
          // Advance the read pointer; words stream one per cycle.
          rd_addr    = dump_idx_q + AW'(1);
          dump_idx_d = dump_idx_q + AW'(1);
        end else begin
          dump_idx_d = '0;
        end
      end
      default: begin
        res_load = 1'b0;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Block table: one write port, one registered read port. Busy holds off
  // commands while a read is outstanding, so no write ever overlaps a read
  // whose result is used.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      start_mem[wr_addr] <= wr_start;
      end_mem[wr_addr]   <= wr_end;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_start_q <= start_mem[rd_addr];
    rd_end_q   <= end_mem[rd_addr];
  end

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      mem_size_q <= MemSizeReset;
      count_q    <= '0;
      used_q     <= 16'd0;
      dump_idx_q <= '0;
      done_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      used_q     <= used_d;
      dump_idx_q <= dump_idx_d;
      done_q     <= res_load;
      if (cfg_valid_i && cfg_ready_o) begin
        mem_size_q <= cfg_data_i;
      end
    end
  end

  // Result payload; only meaningful while done_q is high.
  always_ff @(posedge clk_i) begin
    if (res_load) begin
      status_q <= status_d;
      bs_q     <= bs_d;
      be_q     <= be_d;
      free_q   <= free_d;
      last_q   <= last_d;
    end
  end

  assign busy_o        = (state_q != S_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign done_o        = done_q;
  assign status_o      = status_q;
  assign block_start_o = bs_q;
  assign block_end_o   = be_q;
  assign free_amount_o = free_q;
  assign last_o        = last_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountFull)
    else $error("block count exceeds table depth");

  a_dump_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DUMP) |-> !stack_empty)
    else $error("dump running on an empty stack");

  a_dump_stream : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !last_o) |=> done_o)
    else $error("dump stream broke before its last word");

  a_zero_size : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (cmd_i == CMD_ALLOC) && (size_i == 16'd0))
      |=> (done_o && (status_o == ST_ZERO) && last_o))
    else $error("zero-size allocate not refused");

endmodule
